// File: hdl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared types and constants for the line rasterizer: coordinate widths,
// command codes and the job record passed from the front to the back.
// ----------------------------------------------------------------------------
package lr_pkg;

  localparam int unsigned COORD_BITS = 12;
  localparam int unsigned ERR_BITS   = COORD_BITS + 3;
  localparam int unsigned INCS_BITS  = COORD_BITS + 2;

  // Job queue between front and back.
  localparam int unsigned JQ_DEPTH   = 2;
  localparam int unsigned JQ_PTR_W   = $clog2(JQ_DEPTH);
  localparam int unsigned JQ_CNT_W   = $clog2(JQ_DEPTH + 1);

  typedef enum logic {
    CMD_START   = 1'b0,
    CMD_ADVANCE = 1'b1
  } lr_cmd_e;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS-1:0] delta_t;

  // Classified command with the endpoint setup already worked out.
  typedef struct packed {
    lr_cmd_e cmd;
    coord_t  x0;
    coord_t  y0;
    delta_t  adx;
    delta_t  ady;
    logic    neg_x;
    logic    neg_y;
  } lr_job_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
  } lr_pix_t;

endpackage

// File: hdl/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// All-octant Bresenham line generator with queue-style command and pixel
// channels.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter on push/full. A start command carries both endpoints and
//   yields the first endpoint as a pixel; each advance command yields the
//   next pixel of the running line, with last_pixel_o set on the endpoint.
//   An advance with no line running yields nothing. A start while a line is
//   running drops that line.
//   Pixels leave on empty/pop: the oldest pixel sits on the output ports
//   while empty is low and transfers when pop is high.
//   A transferred command is written into the job queue; the back end then
//   registers its pixel in the output register. Throughput: one command per
//   cycle while full is low. The front classifies commands and computes the
//   deltas; a two-entry job queue separates it from the stepper, so full only
//   rises after the pixel register has stalled.
//   Reset clears the job queue, the output register and the running line;
//   full and empty come up low and high.
//   When the receiver stops popping, the pixel register holds, the back end
//   stops taking jobs, and full rises once the job queue has filled.
// ----------------------------------------------------------------------------
module line_rasterizer_unit import lr_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push,
  output logic   full,
  input  logic   command_i,
  input  coord_t start_x_i,
  input  coord_t start_y_i,
  input  coord_t end_x_i,
  input  coord_t end_y_i,
  output logic   empty,
  input  logic   pop,
  output coord_t pixel_x_o,
  output coord_t pixel_y_o,
  output logic   last_pixel_o
);

  lr_job_t front_job;
  lr_job_t back_job;
  logic    job_valid;
  logic    job_take;
  logic    out_valid;
  lr_pix_t out_pix;

  // Classify the command and set up the line deltas.
  lr_front u_front (
    .cmd_i     (lr_cmd_e'(command_i)),
    .start_x_i (start_x_i),
    .start_y_i (start_y_i),
    .end_x_i   (end_x_i),
    .end_y_i   (end_y_i),
    .job_o     (front_job)
  );

  // Decouple front and back so each side can stall on its own.
  lr_job_queue u_job_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (push),
    .wr_job_i   (front_job),
    .full_o     (full),
    .rd_en_i    (job_take),
    .rd_valid_o (job_valid),
    .rd_job_o   (back_job)
  );

  // Step the line and hold the pixel until it transfers.
  lr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .job_take_o  (job_take),
    .out_valid_o (out_valid),
    .out_pix_o   (out_pix),
    .out_pop_i   (pop)
  );

  assign empty        = !out_valid;
  assign pixel_x_o    = out_pix.x;
  assign pixel_y_o    = out_pix.y;
  assign last_pixel_o = out_pix.last;

endmodule

// File: hdl/lr_front.sv
// ----------------------------------------------------------------------------
// lr_front
// Classify incoming commands; for a start, work out the absolute deltas and
// step directions of the line.
// ----------------------------------------------------------------------------
module lr_front import lr_pkg::*; (
  input  lr_cmd_e cmd_i,
  input  coord_t  start_x_i,
  input  coord_t  start_y_i,
  input  coord_t  end_x_i,
  input  coord_t  end_y_i,
  output lr_job_t job_o
);

  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic signed [COORD_BITS:0] adx_w;
  logic signed [COORD_BITS:0] ady_w;

  assign dx = {end_x_i[COORD_BITS-1], end_x_i} - {start_x_i[COORD_BITS-1], start_x_i};
  assign dy = {end_y_i[COORD_BITS-1], end_y_i} - {start_y_i[COORD_BITS-1], start_y_i};

  assign adx_w = dx[COORD_BITS] ? -dx : dx;
  assign ady_w = dy[COORD_BITS] ? -dy : dy;

  always_comb begin
    job_o.cmd   = cmd_i;
    job_o.x0    = start_x_i;
    job_o.y0    = start_y_i;
    job_o.adx   = adx_w[COORD_BITS-1:0];
    job_o.ady   = ady_w[COORD_BITS-1:0];
    job_o.neg_x = dx[COORD_BITS];
    job_o.neg_y = dy[COORD_BITS];
  end

endmodule

// File: hdl/lr_job_queue.sv
// ----------------------------------------------------------------------------
// lr_job_queue
// Short register queue of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
module lr_job_queue import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_en_i,
  input  lr_job_t wr_job_i,
  output logic    full_o,
  input  logic    rd_en_i,
  output logic    rd_valid_o,
  output lr_job_t rd_job_o
);

  lr_job_t               mem_q [JQ_DEPTH];
  logic [JQ_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [JQ_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [JQ_CNT_W-1:0]   cnt_q, cnt_d;
  logic                  do_wr;
  logic                  do_rd;

  assign full_o     = (cnt_q == JQ_CNT_W'(JQ_DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_job_o   = mem_q[rd_ptr_q];

  assign do_wr = wr_en_i && !full_o;
  assign do_rd = rd_en_i && rd_valid_o;

  // Advance a pointer, wrapping at the queue depth.
  function automatic logic [JQ_PTR_W-1:0] ptr_inc(input logic [JQ_PTR_W-1:0] p);
    logic [JQ_PTR_W-1:0] r;
    if (p == JQ_PTR_W'(JQ_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + JQ_PTR_W'(1);
    end
    return r;
  endfunction

  always_comb begin
    wr_ptr_d = do_wr ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = do_rd ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + JQ_CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - JQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_job_i;
    end
  end

endmodule

// File: hdl/lr_back.sv
// ----------------------------------------------------------------------------
// lr_back
// Bresenham stepper: load a line on start, step one pixel per advance, and
// hold each pixel in an output register until it is taken.
// ----------------------------------------------------------------------------
module lr_back import lr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    job_valid_i,
  input  lr_job_t job_i,
  output logic    job_take_o,
  output logic    out_valid_o,
  output lr_pix_t out_pix_o,
  input  logic    out_pop_i
);

  logic                       active_q, active_d;
  coord_t                     cur_x_q, cur_x_d;
  coord_t                     cur_y_q, cur_y_d;
  logic signed [ERR_BITS-1:0] err_q, err_d;
  logic signed [ERR_BITS-1:0] inc_diag_q, inc_diag_d;
  logic [INCS_BITS-1:0]       inc_str_q, inc_str_d;
  delta_t                     steps_q, steps_d;
  logic                       x_major_q, x_major_d;
  logic                       neg_x_q, neg_x_d;
  logic                       neg_y_q, neg_y_d;
  logic                       out_valid_q, out_valid_d;
  lr_pix_t                    out_pix_q, out_pix_d;

  logic                       emit;
  logic                       x_major_w;
  delta_t                     major_w;
  delta_t                     minor_w;
  coord_t                     step_x;
  coord_t                     step_y;

  // Take a job whenever the output slot is free or being freed.
  assign job_take_o  = job_valid_i && (!out_valid_q || out_pop_i);
  assign out_valid_o = out_valid_q;
  assign out_pix_o   = out_pix_q;

  assign x_major_w = job_i.adx > job_i.ady;
  assign major_w   = x_major_w ? job_i.adx : job_i.ady;
  assign minor_w   = x_major_w ? job_i.ady : job_i.adx;

  assign step_x = neg_x_q ? cur_x_q - coord_t'(1) : cur_x_q + coord_t'(1);
  assign step_y = neg_y_q ? cur_y_q - coord_t'(1) : cur_y_q + coord_t'(1);

  always_comb begin
    active_d   = active_q;
    cur_x_d    = cur_x_q;
    cur_y_d    = cur_y_q;
    err_d      = err_q;
    inc_diag_d = inc_diag_q;
    inc_str_d  = inc_str_q;
    steps_d    = steps_q;
    x_major_d  = x_major_q;
    neg_x_d    = neg_x_q;
    neg_y_d    = neg_y_q;
    out_pix_d  = out_pix_q;
    emit       = 1'b0;

    if (job_take_o) begin
      unique case (job_i.cmd)
        CMD_START: begin
          x_major_d  = x_major_w;
          neg_x_d    = job_i.neg_x;
          neg_y_d    = job_i.neg_y;
          err_d      = $signed({2'b00, minor_w, 1'b0}) - $signed({3'b000, major_w});
          inc_diag_d = $signed({2'b00, minor_w, 1'b0}) - $signed({2'b00, major_w, 1'b0});
          inc_str_d  = {1'b0, minor_w, 1'b0};
          steps_d    = major_w;
          cur_x_d    = job_i.x0;
          cur_y_d    = job_i.y0;
          active_d   = (major_w != '0);
          emit       = 1'b1;
          out_pix_d  = '{x: job_i.x0, y: job_i.y0, last: (major_w == '0)};
        end
        CMD_ADVANCE: begin
          if (active_q) begin
            if (!err_q[ERR_BITS-1]) begin
              if (x_major_q) begin
                cur_y_d = step_y;
              end else begin
                cur_x_d = step_x;
              end
              err_d = err_q + inc_diag_q;
            end else begin
              err_d = err_q + $signed({1'b0, inc_str_q});
            end
            if (x_major_q) begin
              cur_x_d = step_x;
            end else begin
              cur_y_d = step_y;
            end
            steps_d   = steps_q - delta_t'(1);
            active_d  = (steps_q != delta_t'(1));
            emit      = 1'b1;
            out_pix_d = '{x: cur_x_d, y: cur_y_d, last: (steps_q == delta_t'(1))};
          end
        end
        default: begin
        end
      endcase
    end

    out_valid_d = (out_valid_q && !out_pop_i) || emit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      active_q    <= active_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    err_q      <= err_d;
    inc_diag_q <= inc_diag_d;
    inc_str_q  <= inc_str_d;
    steps_q    <= steps_d;
    x_major_q  <= x_major_d;
    neg_x_q    <= neg_x_d;
    neg_y_q    <= neg_y_d;
    out_pix_q  <= out_pix_d;
  end

endmodule

// File: hdl/lr_checker.sv
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks on the line rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module lr_checker import lr_pkg::*; (
  input logic   clk_i,
  input logic   rst_ni,
  input logic   full,
  input logic   empty,
  input logic   pop,
  input coord_t pixel_x_o,
  input coord_t pixel_y_o,
  input logic   last_pixel_o
);

  // Hold a waiting pixel until it transfers.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(pixel_x_o) && $stable(pixel_y_o)
                          && $stable(last_pixel_o)))
    else $error("pixel changed or vanished while stalled");

  // Come out of reset with no pixel pending and room for commands.
  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> (empty && !full))
    else $error("channels not clear after reset");

  // The job queue only fills while the pixel register is stalled.
  a_full_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full |-> !empty)
    else $error("job queue full with no pixel waiting");

endmodule

bind line_rasterizer_unit lr_checker u_lr_checker (.*);

// File: tb/line_rasterizer_unit_tb.sv
// ----------------------------------------------------------------------------
// line_rasterizer_unit_tb
// Self-checking bench for the Bresenham line generator. Commands go in
// through the push/full side and pixels come out through the empty/pop side.
// Each accepted command drives a pixel predictor. Each popped pixel is
// compared with the oldest predicted one. Directed lines cover the corner
// cases. Random lines of mostly short length then run under varying idle
// patterns on both sides.
// ----------------------------------------------------------------------------
module line_rasterizer_unit_tb;
  import lr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned RANDOM_ITEMS = 1200;
  localparam int          SHORT_REACH = 16;
  localparam int          LONG_REACH = 256;
  localparam int unsigned FULL_LONG_LINES = 2;

  // Pixel predictor plus the queue of pixels still owed by the block.
  class pixel_scoreboard;
    bit                          running;
    coord_t                      cur_x;
    coord_t                      cur_y;
    logic signed [ERR_BITS-1:0]  err;
    logic signed [ERR_BITS-1:0]  diag_inc;
    logic        [INCS_BITS-1:0] straight_inc;
    delta_t                      remaining;
    bit                          along_x;
    bit                          neg_x;
    bit                          neg_y;
    lr_pix_t                     owed_pixels[$];
    int                          errors;

    function new();
      running = 1'b0;
      cur_x = '0;
      cur_y = '0;
      err = '0;
      diag_inc = '0;
      straight_inc = '0;
      remaining = '0;
      along_x = 1'b0;
      neg_x = 1'b0;
      neg_y = 1'b0;
      errors = 0;
    endfunction

    function void note_command(lr_cmd_e cmd, coord_t x0, coord_t y0, coord_t x1, coord_t y1);
      int      dx;
      int      dy;
      int      major;
      int      minor;
      lr_pix_t pix;
      if (cmd == CMD_START) begin
        dx = int'(x1) - int'(x0);
        dy = int'(y1) - int'(y0);
        neg_x = dx < 0;
        neg_y = dy < 0;
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        // y wins a tie
        along_x = dx > dy;
        major = along_x ? dx : dy;
        minor = along_x ? dy : dx;
        err = ERR_BITS'(2 * minor - major);
        diag_inc = ERR_BITS'(2 * (minor - major));
        straight_inc = INCS_BITS'(2 * minor);
        remaining = delta_t'(major);
        cur_x = x0;
        cur_y = y0;
        running = remaining != '0;
      end else if (!running) begin
        return;
      end else begin
        if (!err[ERR_BITS-1]) begin
          if (along_x) cur_y = coord_t'(cur_y + (neg_y ? -1 : 1));
          else         cur_x = coord_t'(cur_x + (neg_x ? -1 : 1));
          err = err + diag_inc;
        end else begin
          err = err + $signed({1'b0, straight_inc});
        end
        if (along_x) cur_x = coord_t'(cur_x + (neg_x ? -1 : 1));
        else         cur_y = coord_t'(cur_y + (neg_y ? -1 : 1));
        remaining = remaining - delta_t'(1);
        running = remaining != '0;
      end
      pix.x = cur_x;
      pix.y = cur_y;
      pix.last = remaining == '0;
      owed_pixels.push_back(pix);
    endfunction

    function void check_pixel(coord_t x, coord_t y, logic last);
      lr_pix_t want;
      if (owed_pixels.size() == 0) begin
        $display("%0t: pixel with none owed: x=%0d y=%0d last=%0b", $time, x, y, last);
        errors++;
        return;
      end
      want = owed_pixels.pop_front();
      if (want.x !== x) begin
        $display("%0t: pixel_x_o expected %0d actual %0d", $time, want.x, x);
        errors++;
      end
      if (want.y !== y) begin
        $display("%0t: pixel_y_o expected %0d actual %0d", $time, want.y, y);
        errors++;
      end
      if (want.last !== last) begin
        $display("%0t: last_pixel_o expected %0b actual %0b", $time, want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   push = 1'b0;
  logic   full;
  logic   command_i = CMD_START;
  coord_t start_x_i = '0;
  coord_t start_y_i = '0;
  coord_t end_x_i = '0;
  coord_t end_y_i = '0;
  logic   empty;
  logic   pop = 1'b0;
  coord_t pixel_x_o;
  coord_t pixel_y_o;
  logic   last_pixel_o;

  pixel_scoreboard pixels = new();

  int unsigned push_idle_pct = 15;
  int unsigned pop_idle_pct = 63;
  int unsigned commands_sent = 0;
  int unsigned cycle_count = 0;

  line_rasterizer_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push         (push),
    .full         (full),
    .command_i    (command_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .empty        (empty),
    .pop          (pop),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  // 8 ns clock.
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Hard stop in case the block hangs or loses a pixel for good.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: decide once per edge whether to pop, so pop gets one update per step.
  always @(posedge clk_i) begin
    pop <= ($urandom_range(99) >= pop_idle_pct);
  end

  // Observe both handshakes with the values seen just before the edge.
  // Check the popped pixel first: it is always older than a command
  // accepted at the same edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) pixels.check_pixel(pixel_x_o, pixel_y_o, last_pixel_o);
      if (push && !full) begin
        pixels.note_command(lr_cmd_e'(command_i), start_x_i, start_y_i, end_x_i, end_y_i);
      end
    end
  end

  function automatic coord_t rand_coord();
    return coord_t'($urandom);
  endfunction

  // Pick a point within reach of base, mirrored back if it would leave the range.
  function automatic coord_t near_coord(coord_t base, int reach);
    int offset;
    int pos;
    offset = int'($urandom_range(2 * reach)) - reach;
    pos = int'(base) + offset;
    if (pos > 2047 || pos < -2048) pos = int'(base) - offset;
    return coord_t'(pos);
  endfunction

  function automatic int line_span(coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    int dx;
    int dy;
    dx = int'(x1) - int'(x0);
    dy = int'(y1) - int'(y0);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  // Present one command and hold it until the block takes the transfer.
  // Push is left high afterwards; the next call or the caller decides.
  task automatic send_command(lr_cmd_e cmd, coord_t x0, coord_t y0, coord_t x1, coord_t y1);
    while ($urandom_range(99) < push_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push <= 1'b1;
    command_i <= cmd;
    start_x_i <= x0;
    start_y_i <= y0;
    end_x_i <= x1;
    end_y_i <= y1;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    commands_sent++;
  endtask

  // The endpoint fields are ignored on advance; fill them with noise anyway.
  task automatic send_advance();
    send_command(CMD_ADVANCE, rand_coord(), rand_coord(), rand_coord(), rand_coord());
  endtask

  task automatic run_line(coord_t x0, coord_t y0, coord_t x1, coord_t y1, int advances);
    send_command(CMD_START, x0, y0, x1, y1);
    repeat (advances) send_advance();
  endtask

  // Hold the sender off until every owed pixel has come out.
  task automatic drain_pixels();
    push <= 1'b0;
    while (pixels.owed_pixels.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;
    int     span;
    int     kind;
    int     full_long_lines;
    bit     phase_two_seen;

    full_long_lines = 0;
    phase_two_seen = 1'b0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // ---- Directed lines ----
    // Single point: one pixel marked last, block stays idle.
    run_line(12'sd0, 12'sd0, 12'sd0, 12'sd0, 0);
    // Advance while idle, with extreme values in the ignored fields.
    send_command(CMD_ADVANCE, 12'sd2047, -12'sd2048, 12'sd2047, -12'sd2048);
    // Full diagonal corner to corner, cut short by a restart.
    run_line(-12'sd2048, -12'sd2048, 12'sd2047, 12'sd2047, 2);
    // Opposite corners, x falling and y rising, equal deltas so y leads.
    run_line(12'sd2047, -12'sd2048, -12'sd2048, 12'sd2047, 1);
    // Shallow x-major line run to its end, then one advance past it.
    run_line(12'sd0, 12'sd0, 12'sd5, 12'sd2, 5);
    send_advance();
    // Steep y-major line with both directions negative, run to its end.
    run_line(12'sd3, 12'sd7, 12'sd1, 12'sd0, 7);
    // Full-width horizontal and full-height vertical lines, cut short.
    run_line(-12'sd2048, 12'sd5, 12'sd2047, 12'sd5, 2);
    run_line(12'sd10, 12'sd2047, 12'sd10, -12'sd2048, 1);
    // Restart while running on a fresh short line and let it finish.
    run_line(12'sd0, 12'sd0, -12'sd3, 12'sd1, 3);

    // ---- Random lines ----
    commands_sent = 0;
    while (commands_sent < RANDOM_ITEMS) begin
      // Swap idle profiles a third of the way in, then drop idling entirely.
      if (commands_sent >= RANDOM_ITEMS / 3 && !phase_two_seen) begin
        phase_two_seen = 1'b1;
        drain_pixels();
        push_idle_pct = 63;
        pop_idle_pct = 15;
      end
      if (commands_sent >= 2 * RANDOM_ITEMS / 3) begin
        push_idle_pct = 0;
        pop_idle_pct = 0;
      end

      kind = int'($urandom_range(99));
      x0 = rand_coord();
      y0 = rand_coord();
      if (kind < 70) begin
        // Complete short line, sometimes with idle advances after it.
        x1 = near_coord(x0, SHORT_REACH);
        y1 = near_coord(y0, SHORT_REACH);
        span = line_span(x0, y0, x1, y1);
        run_line(x0, y0, x1, y1, span + int'($urandom_range(2)));
      end else if (kind < 85) begin
        // Short line, usually dropped part way by the next start.
        x1 = near_coord(x0, SHORT_REACH);
        y1 = near_coord(y0, SHORT_REACH);
        span = line_span(x0, y0, x1, y1);
        run_line(x0, y0, x1, y1, int'($urandom_range(span)));
      end else if (kind < 97) begin
        // Single loose command of either kind.
        if ($urandom_range(1)) send_command(CMD_START, x0, y0, rand_coord(), rand_coord());
        else send_advance();
      end else begin
        // Longer line; only a couple of moderate length are run to the end,
        // the rest span the full range and get dropped early.
        if (full_long_lines < FULL_LONG_LINES) begin
          full_long_lines++;
          x1 = near_coord(x0, LONG_REACH);
          y1 = near_coord(y0, LONG_REACH);
          span = line_span(x0, y0, x1, y1);
          run_line(x0, y0, x1, y1, span);
        end else begin
          x1 = rand_coord();
          y1 = rand_coord();
          run_line(x0, y0, x1, y1, int'($urandom_range(20)));
        end
      end
    end

    // ---- Wind down ----
    drain_pixels();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (pixels.errors == 0 && pixels.owed_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
